// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define KMM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("kmmst: implication check failed");

// Next-cycle implication, disabled while reset is asserted
`define KMM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("kmmst: next-cycle check failed");

`endif

// ===== rtl/kmmst_pkg.sv =====
// ----------------------------------------------------------------------------
// kmmst_pkg
// Types, sizes and status codes of the keyed min/max/sum statistics table.
// ----------------------------------------------------------------------------
package kmmst_pkg;

	// Table geometry
	localparam int TABLE_ENTRIES = 256;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

	// Field widths
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int SIDE_W  = 4;
	localparam int HCNT_W  = 32;
	localparam int SUM_W   = 48;
	localparam int EIDX_W  = 8;
	localparam int UNIQ_W  = 9;

	// Configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic ADDR_REC_EN = 1'b0;   // word select bit of the register

	// Result status codes
	localparam logic [1:0] ST_UPDATED  = 2'd0;
	localparam logic [1:0] ST_INSERTED = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_DISABLED = 2'd3;

	typedef struct packed {
		logic signed [KEY_W-1:0]  stat_key;
		logic signed [VAL_W-1:0]  sample_value;
		logic        [SIDE_W-1:0] side_tag;
	} sample_t;

	typedef struct packed {
		logic        [1:0]        status;
		logic        [EIDX_W-1:0] entry_index;
		logic        [HCNT_W-1:0] hit_count;
		logic signed [VAL_W-1:0]  min_value;
		logic signed [VAL_W-1:0]  max_value;
		logic signed [SUM_W-1:0]  sum_value;
		logic        [UNIQ_W-1:0] unique_entries;
	} result_t;

	// One stored table entry
	typedef struct packed {
		logic        [KEY_W-1:0]  key;
		logic        [HCNT_W-1:0] cnt;
		logic signed [VAL_W-1:0]  mn;
		logic signed [VAL_W-1:0]  mx;
		logic signed [SUM_W-1:0]  sum;
		logic        [SIDE_W-1:0] side;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Request to the entry update unit
	typedef struct packed {
		logic    insert;
		entry_t  old_entry;
		sample_t smp;
	} upd_req_t;

endpackage

// ===== rtl/kmmst_ram.sv =====
// ----------------------------------------------------------------------------
// kmmst_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module kmmst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port, data held while not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/kmmst_upd.sv =====
// ----------------------------------------------------------------------------
// kmmst_upd
// Entry update unit: saturating count and sum, signed min/max, fresh insert.
// ----------------------------------------------------------------------------
module kmmst_upd (
	input  kmmst_pkg::upd_req_t req,
	output kmmst_pkg::entry_t   new_entry
);
	import kmmst_pkg::*;

	logic [SUM_W:0]   sum_wide;
	logic [SUM_W-1:0] sum_sat;
	logic [SUM_W-1:0] val_ext;
	logic [HCNT_W-1:0] cnt_next;

	// Widen the sample to the sum width
	assign val_ext = {{(SUM_W-VAL_W){req.smp.sample_value[VAL_W-1]}}, req.smp.sample_value};

	// Add with one guard bit, clamp on overflow
	always_comb begin
		sum_wide = {req.old_entry.sum[SUM_W-1], req.old_entry.sum}
			+ {val_ext[SUM_W-1], val_ext};
		if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
			sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sum_sat = sum_wide[SUM_W-1:0];
		end
	end

	// Hold the count at all ones
	assign cnt_next = (&req.old_entry.cnt) ? req.old_entry.cnt
		: req.old_entry.cnt + HCNT_W'(1);

	// Build the new entry
	always_comb begin
		new_entry.key  = req.smp.stat_key;
		new_entry.side = req.smp.side_tag;
		if (req.insert) begin
			new_entry.cnt = HCNT_W'(1);
			new_entry.mn  = req.smp.sample_value;
			new_entry.mx  = req.smp.sample_value;
			new_entry.sum = val_ext;
		end else begin
			new_entry.cnt = cnt_next;
			new_entry.mn  = ($signed(req.smp.sample_value) < $signed(req.old_entry.mn))
				? req.smp.sample_value : req.old_entry.mn;
			new_entry.mx  = ($signed(req.smp.sample_value) > $signed(req.old_entry.mx))
				? req.smp.sample_value : req.old_entry.mx;
			new_entry.sum = sum_sat;
		end
	end

endmodule

// ===== rtl/keyed_min_max_sum_table_unit.sv =====
// ----------------------------------------------------------------------------
// keyed_min_max_sum_table_unit
// Per-key statistics table: count, min, max and saturating sum per key.
// ----------------------------------------------------------------------------
//  channel   | direction | payload  | handshake
//  sample    | in        | sample_t | sample_valid / sample_ready
//  result    | out       | result_t | result_valid / result_ready
//  config    | in        | 32 bit   | psel / penable / pwrite, pready high
//
//  An accepted sample is compared with the stored entries in order, one stored
//  entry per cycle through the one RAM read port; a hit updates that entry, a
//  miss appends a new one or reports full, and when disabled no search is made.
//  The next sample is taken only once the result is in the output register.
//  Reset clears the entry count and the enable; only entries below the count are read.
//  A stalled result sits in the output register while the next item runs.
// ----------------------------------------------------------------------------
module keyed_min_max_sum_table_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sample_valid,
	output logic                              sample_ready,
	input  kmmst_pkg::sample_t                sample,
	output logic                              result_valid,
	input  logic                              result_ready,
	output kmmst_pkg::result_t                result,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [kmmst_pkg::PADDR_W-1:0]     paddr,
	input  logic [kmmst_pkg::PDATA_W-1:0]     pwdata,
	output logic [kmmst_pkg::PDATA_W-1:0]     prdata,
	output logic                              pready
);
	import kmmst_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SRCH,
		S_UPD,
		S_MISS,
		S_DONE
	} state_t;

	state_t            state_q;
	logic              rec_en_q;
	logic [CNT_W-1:0]  used_q;
	logic [CNT_W-1:0]  issue_q;
	logic              pend_q;
	logic [IDX_W-1:0]  pend_idx_q;
	logic [IDX_W-1:0]  hit_idx_q;
	sample_t           smp_q;
	result_t           res_q;
	result_t           out_q;
	logic              out_vld_q;

	logic              issue_more;
	logic              hit;
	logic              room;
	logic              rd_en;
	logic              wr_en;
	logic              out_load;
	logic [IDX_W-1:0]  wr_addr;
	logic [ENTRY_W-1:0] rd_raw;
	entry_t            rd_entry;
	entry_t            new_entry;
	upd_req_t          upd_req;

	// Configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == ADDR_REC_EN) ? PDATA_W'(rec_en_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_en_q <= 1'b0;
		end else if (psel && penable && pwrite && (paddr[2] == ADDR_REC_EN)) begin
			rec_en_q <= pwdata[0];
		end
	end

	// Entry storage
	kmmst_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (new_entry),
		.rd_en   (rd_en),
		.rd_addr (issue_q[IDX_W-1:0]),
		.rd_data (rd_raw)
	);

	assign rd_entry = entry_t'(rd_raw);

	// Search control: compare the entry read last cycle, issue the next read
	assign issue_more = (issue_q < used_q);
	assign hit        = pend_q && (rd_entry.key == smp_q.stat_key);
	assign rd_en      = (state_q == S_SRCH) && issue_more && !hit;
	assign room       = (used_q < CNT_W'(TABLE_ENTRIES));

	// Shared update unit
	assign upd_req.insert    = (state_q == S_MISS);
	assign upd_req.old_entry = rd_entry;
	assign upd_req.smp       = smp_q;

	kmmst_upd u_upd (
		.req       (upd_req),
		.new_entry (new_entry)
	);

	// Write back the updated or appended entry
	assign wr_en   = (state_q == S_UPD) || ((state_q == S_MISS) && room);
	assign wr_addr = (state_q == S_UPD) ? hit_idx_q : used_q[IDX_W-1:0];

	// Hand a finished result to the output register once it is free
	assign out_load = (state_q == S_DONE) && (!out_vld_q || result_ready);

	assign sample_ready = (state_q == S_IDLE);
	assign result_valid = out_vld_q;
	assign result       = out_q;

	// Sequencer with result and output registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			used_q     <= '0;
			issue_q    <= '0;
			pend_q     <= 1'b0;
			pend_idx_q <= '0;
			hit_idx_q  <= '0;
			out_vld_q  <= 1'b0;
			smp_q      <= '0;
			res_q      <= '0;
			out_q      <= '0;
		end else begin
			// load the output, or drop it once its transfer completes
			if (out_load) begin
				out_q     <= res_q;
				out_vld_q <= 1'b1;
			end else if (result_ready) begin
				out_vld_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (sample_valid) begin
						smp_q   <= sample;
						issue_q <= '0;
						pend_q  <= 1'b0;
						if (rec_en_q) begin
							state_q <= S_SRCH;
						end else begin
							res_q   <= '{status: ST_DISABLED, entry_index: '0,
								hit_count: '0, min_value: '0, max_value: '0,
								sum_value: '0, unique_entries: UNIQ_W'(used_q)};
							state_q <= S_DONE;
						end
					end
				end
				S_SRCH: begin
					pend_q     <= rd_en;
					pend_idx_q <= issue_q[IDX_W-1:0];
					if (rd_en) begin
						issue_q <= issue_q + CNT_W'(1);
					end
					if (hit) begin
						hit_idx_q <= pend_idx_q;
						state_q   <= S_UPD;
					end else if (!pend_q && !issue_more) begin
						state_q <= S_MISS;
					end
				end
				S_UPD: begin
					res_q.status         <= ST_UPDATED;
					res_q.entry_index    <= EIDX_W'(hit_idx_q);
					res_q.hit_count      <= new_entry.cnt;
					res_q.min_value      <= new_entry.mn;
					res_q.max_value      <= new_entry.mx;
					res_q.sum_value      <= new_entry.sum;
					res_q.unique_entries <= UNIQ_W'(used_q);
					state_q              <= S_DONE;
				end
				S_MISS: begin
					if (room) begin
						res_q.status         <= ST_INSERTED;
						res_q.entry_index    <= EIDX_W'(used_q);
						res_q.hit_count      <= new_entry.cnt;
						res_q.min_value      <= new_entry.mn;
						res_q.max_value      <= new_entry.mx;
						res_q.sum_value      <= new_entry.sum;
						res_q.unique_entries <= UNIQ_W'(used_q + CNT_W'(1));
						used_q               <= used_q + CNT_W'(1);
					end else begin
						res_q <= '{status: ST_FULL, entry_index: '0,
							hit_count: '0, min_value: '0, max_value: '0,
							sum_value: '0, unique_entries: UNIQ_W'(used_q)};
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					// advance once the output register has taken the result
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/kmmst_chk.sv =====
// ----------------------------------------------------------------------------
// kmmst_chk
// Port-level checks of the statistics table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kmmst_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          sample_valid,
	input logic                          sample_ready,
	input logic                          result_valid,
	input logic                          result_ready,
	input kmmst_pkg::result_t            result,
	input logic                          psel,
	input logic                          penable,
	input logic                          pwrite,
	input logic [kmmst_pkg::PADDR_W-1:0] paddr,
	input logic [kmmst_pkg::PDATA_W-1:0] pwdata,
	input logic [kmmst_pkg::PDATA_W-1:0] prdata,
	input logic                          pready
);
	import kmmst_pkg::*;

	logic smp_xfer;
	logic en_write;

	assign smp_xfer = sample_valid && sample_ready;
	assign en_write = psel && penable && pwrite && pready && (paddr[2] == ADDR_REC_EN);

	// The unit works one item at a time: busy right after a transfer
	`KMM_ASSERT_NXT(a_busy_after_xfer, clk, arst_n, smp_xfer, !sample_ready)

	// A stalled result holds
	`KMM_ASSERT_NXT(a_result_hold, clk, arst_n, result_valid && !result_ready,
		result_valid && $stable(result))

	// The enable register reads back what was written
	`KMM_ASSERT_IMP(a_cfg_readback, clk, arst_n,
		$past(en_write) && (paddr[2] == ADDR_REC_EN), prdata[0] == $past(pwdata[0]))

	// A fresh entry holds exactly one sample
	`KMM_ASSERT_IMP(a_insert_fresh, clk, arst_n,
		result_valid && (result.status == ST_INSERTED),
		(result.hit_count == 32'd1) && (result.min_value == result.max_value)
		&& (result.unique_entries != '0))

endmodule

bind keyed_min_max_sum_table_unit kmmst_chk u_kmmst_chk (.*);
